// ----- design/pdrd_pkg.sv -----
// ----------------------------------------------------------------------------
// pdrd_pkg: shared types and constants of the packed distribution decoder
// Item structs for both channels, default sizes and the run width table.
// ----------------------------------------------------------------------------
package pdrd_pkg;

    localparam int MAX_ENTRIES_DEF  = 30;
    localparam int RECORD_BYTES_DEF = 64;

    localparam int NUM_RUNS = 5;
    localparam logic [2:0] RUNS_DONE = 3'd5;

    typedef struct packed {
        logic [7:0] record_byte;
        logic       start_of_record;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  entry_index;
        logic [23:0] entry_millionths;
        logic        last_entry;
        logic        format_error;
    } t_out_item;

    // Byte width of the values in each run.
    function automatic logic [1:0] run_width(input logic [2:0] run);
        logic [1:0] w;
        unique case (run)
            3'd0:    w = 2'd1;
            3'd1:    w = 2'd2;
            3'd2:    w = 2'd3;
            3'd3:    w = 2'd2;
            default: w = 2'd1;
        endcase
        return w;
    endfunction

endpackage

// ----- design/pdrd_out_stage.sv -----
// ----------------------------------------------------------------------------
// pdrd_out_stage: output holding register
// Hold one result item until the consumer takes it; free when empty or taken.
// ----------------------------------------------------------------------------
module pdrd_out_stage
    import pdrd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_item,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);

    logic      r_valid;
    t_out_item r_item;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_item <= i_item;
        end
    end

endmodule

// ----- design/packed_distribution_record_decoder_top.sv -----
// ----------------------------------------------------------------------------
// packed_distribution_record_decoder_top: packed distribution record decoder
// Expand a fixed-length packed record, one byte per item, into MAX_ENTRIES
// entries in millionths: leading zeros, five runs of big-endian values of
// 1, 2, 3, 2 and 1 bytes, then zero padding.
// ----------------------------------------------------------------------------
// Flow: a byte is accepted only in the idle state, after the previous one is
// done. A header or value byte that emits nothing is accepted, then passes the
// end-of-record check; a byte ignored while waiting for a start is dropped. A
// byte that ends a value emits it and scans the runs if its run is spent; the
// last header byte emits the leading zeros, then scans. Entries are registered
// in the output stage. Reset (synchronous, active low) waits for a start.
// ----------------------------------------------------------------------------
module packed_distribution_record_decoder_top
    import pdrd_pkg::*;
#(
    parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
    parameter int RECORD_BYTES = RECORD_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int PW = $clog2(RECORD_BYTES);
    localparam int EW = $clog2(MAX_ENTRIES + 1);

    // Header byte positions.
    localparam logic [PW-1:0] POS_LEAD   = PW'(0);
    localparam logic [PW-1:0] POS_RUNS_A = PW'(1);
    localparam logic [PW-1:0] POS_RUNS_B = PW'(2);
    localparam logic [PW-1:0] POS_RUNS_C = PW'(3);
    localparam logic [PW-1:0] POS_LAST   = PW'(RECORD_BYTES - 1);

    localparam logic [EW-1:0] EMIT_MAX  = EW'(MAX_ENTRIES);
    localparam logic [EW-1:0] EMIT_LAST = EW'(MAX_ENTRIES - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;  // ready for the next byte
    localparam logic [2:0] S_ZERO  = 3'd1;  // emit leading zero entries
    localparam logic [2:0] S_VAL   = 3'd2;  // emit one completed value
    localparam logic [2:0] S_SEEK  = 3'd3;  // scan one run per cycle
    localparam logic [2:0] S_FILL  = 3'd4;  // pad with zero entries
    localparam logic [2:0] S_FINAL = 3'd5;  // end-of-record check

    logic [2:0]    r_state,    n_state;
    logic [PW-1:0] r_pos,      n_pos;
    logic [3:0]    r_counts [NUM_RUNS];
    logic [3:0]    n_counts [NUM_RUNS];
    logic [2:0]    r_run,      n_run;
    logic [3:0]    r_remain,   n_remain;
    logic [15:0]   r_acc,      n_acc;
    logic [1:0]    r_left,     n_left;
    logic [EW-1:0] r_emitted,  n_emitted;
    logic          r_done,     n_done;
    logic [7:0]    r_lead,     n_lead;
    logic          r_err,      n_err;
    logic [7:0]    r_zero_cnt, n_zero_cnt;
    logic [2:0]    r_seek,     n_seek;
    logic          r_last,     n_last;
    logic [23:0]   r_val,      n_val;

    logic          in_acc;
    logic [PW-1:0] pos;
    logic [7:0]    b;
    logic          full;
    logic          out_free;
    logic          emit;
    logic [23:0]   emit_value;
    logic [9:0]    total;
    logic [9:0]    nbytes;
    t_out_item     emit_item;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign b          = i_in_data.record_byte;
    assign pos        = i_in_data.start_of_record ? POS_LEAD : r_pos;
    assign full       = (r_emitted >= EMIT_MAX);

    // Header totals, checked when the last run count arrives.
    assign total  = 10'(r_lead) + 10'(r_counts[0]) + 10'(r_counts[1])
                  + 10'(r_counts[2]) + 10'(r_counts[3]) + 10'(b[7:4]);
    assign nbytes = 10'(r_counts[0]) + 10'({r_counts[1], 1'b0})
                  + 10'(r_counts[2]) + 10'({r_counts[2], 1'b0})
                  + 10'({r_counts[3], 1'b0}) + 10'(b[7:4]);

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_counts   = r_counts;
        n_run      = r_run;
        n_remain   = r_remain;
        n_acc      = r_acc;
        n_left     = r_left;
        n_emitted  = r_emitted;
        n_done     = r_done;
        n_lead     = r_lead;
        n_err      = r_err;
        n_zero_cnt = r_zero_cnt;
        n_seek     = r_seek;
        n_last     = r_last;
        n_val      = r_val;
        emit       = 1'b0;
        emit_value = 24'd0;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    // Start of record: drop whatever was in progress.
                    if (i_in_data.start_of_record) begin
                        for (int i = 0; i < NUM_RUNS; i++) begin
                            n_counts[i] = 4'd0;
                        end
                        n_run     = 3'd0;
                        n_remain  = 4'd0;
                        n_acc     = 16'd0;
                        n_left    = 2'd0;
                        n_emitted = '0;
                        n_lead    = 8'd0;
                        n_err     = 1'b0;
                        n_done    = 1'b0;
                    end
                    if (i_in_data.start_of_record || !r_done) begin
                        n_pos   = pos + PW'(1);
                        n_last  = (pos >= POS_LAST);
                        n_state = S_FINAL;
                        if (pos >= POS_LAST) begin
                            n_done = 1'b1;
                        end
                        if (pos == POS_LEAD) begin
                            n_lead = b;
                        end else if (pos == POS_RUNS_A) begin
                            n_counts[0] = b[7:4];
                            n_counts[1] = b[3:0];
                        end else if (pos == POS_RUNS_B) begin
                            n_counts[2] = b[7:4];
                            n_counts[3] = b[3:0];
                        end else if (pos == POS_RUNS_C) begin
                            n_counts[4] = b[7:4];
                            n_err       = (total > 10'(MAX_ENTRIES))
                                       || (nbytes > 10'(RECORD_BYTES - 4));
                            n_zero_cnt  = r_lead;
                            n_state     = S_ZERO;
                        end else if (r_run < RUNS_DONE) begin
                            if (r_left <= 2'd1) begin
                                n_val   = {r_acc, b};
                                n_acc   = 16'd0;
                                n_state = S_VAL;
                            end else begin
                                n_acc  = {r_acc[7:0], b};
                                n_left = r_left - 2'd1;
                            end
                        end
                    end
                end
            end
            S_ZERO: begin
                if (r_zero_cnt != 8'd0 && !full) begin
                    emit = 1'b1;
                    if (out_free) begin
                        n_zero_cnt = r_zero_cnt - 8'd1;
                        n_emitted  = r_emitted + EW'(1);
                    end
                end else begin
                    n_seek  = 3'd0;
                    n_state = S_SEEK;
                end
            end
            S_VAL: begin
                emit       = 1'b1;
                emit_value = r_val;
                if (out_free) begin
                    n_emitted = r_emitted + EW'(1);
                    n_remain  = r_remain - 4'd1;
                    if (r_emitted >= EMIT_LAST) begin
                        n_run   = RUNS_DONE;
                        n_state = S_FINAL;
                    end else if (r_remain == 4'd1) begin
                        n_seek  = r_run + 3'd1;
                        n_state = S_SEEK;
                    end else begin
                        n_left  = run_width(r_run);
                        n_state = S_FINAL;
                    end
                end
            end
            S_SEEK: begin
                if (full) begin
                    n_run   = RUNS_DONE;
                    n_state = S_FINAL;
                end else if (r_seek >= RUNS_DONE) begin
                    n_state = S_FILL;
                end else if (r_counts[r_seek] == 4'd0) begin
                    n_seek = r_seek + 3'd1;
                end else begin
                    n_run    = r_seek;
                    n_remain = r_counts[r_seek];
                    n_left   = run_width(r_seek);
                    n_acc    = 16'd0;
                    n_state  = S_FINAL;
                end
            end
            S_FILL: begin
                if (!full) begin
                    emit = 1'b1;
                    if (out_free) begin
                        n_emitted = r_emitted + EW'(1);
                    end
                end else begin
                    n_run   = RUNS_DONE;
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                // Last byte with runs still open: zero-fill the rest.
                if (r_last && r_run < RUNS_DONE) begin
                    n_state = S_FILL;
                end else begin
                    n_last  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        emit_item.entry_index      = 5'(r_emitted);
        emit_item.entry_millionths = emit_value;
        emit_item.last_entry       = (r_emitted == EMIT_LAST);
        emit_item.format_error     = r_err;
    end

    pdrd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_item  (emit_item),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_data)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_run      <= 3'd0;
            r_remain   <= 4'd0;
            r_left     <= 2'd0;
            r_emitted  <= '0;
            r_done     <= 1'b1;
            r_lead     <= 8'd0;
            r_err      <= 1'b0;
            r_zero_cnt <= 8'd0;
            r_seek     <= 3'd0;
            r_last     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_run      <= n_run;
            r_remain   <= n_remain;
            r_left     <= n_left;
            r_emitted  <= n_emitted;
            r_done     <= n_done;
            r_lead     <= n_lead;
            r_err      <= n_err;
            r_zero_cnt <= n_zero_cnt;
            r_seek     <= n_seek;
            r_last     <= n_last;
        end
    end

    // Payload state: always written before it is read in a record.
    always_ff @(posedge i_clk) begin
        r_counts <= n_counts;
        r_acc    <= n_acc;
        r_val    <= n_val;
    end

endmodule

// ----- sim/packed_distribution_record_decoder_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_distribution_record_decoder_top_test: record decoder testbench
// Feed packed records byte by byte into the decoder and check every emitted
// entry against an in-bench decoder model. A short directed table comes
// first, then random records: mostly well-formed, some overrunning, some cut
// short by a restart, with stray bytes between them. Both sides stall at
// random.
// ----------------------------------------------------------------------------
module packed_distribution_record_decoder_top_test;
    import pdrd_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 12;
    localparam int RAND_ITEMS   = 480;
    localparam int QUIET_ITEMS  = RAND_ITEMS * 85 / 100;
    localparam int TAIL_CYCLES  = 16;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int VALUE_ROOM   = RECORD_BYTES_DEF - 4;

    // Byte width of the values held in each run.
    localparam logic [1:0] VAL_BYTES [NUM_RUNS] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd1};

    // One row of the directed table. Where chk is set, the number of entries
    // the byte causes, and the value and error flag of the first one, are
    // given by hand and cross-checked against the decoder model.
    typedef struct packed {
        logic [7:0]  byte_val;
        logic        sor;
        logic        chk;
        logic [5:0]  n_entries;
        logic [23:0] first_val;
        logic        err;
    } t_row;

    localparam int DIR_ROWS = 23;
    localparam t_row DIR_TABLE [DIR_ROWS] = '{
        // byte before any start is ignored
        '{8'hAA, 1'b0, 1'b1, 6'd0,  24'h000000, 1'b0},
        // record: 2 leading zeros, one value in each run, then padding
        '{8'h02, 1'b1, 1'b1, 6'd0,  24'h000000, 1'b0},
        '{8'h11, 1'b0, 1'b1, 6'd0,  24'h000000, 1'b0},
        '{8'h11, 1'b0, 1'b1, 6'd0,  24'h000000, 1'b0},
        '{8'h1F, 1'b0, 1'b1, 6'd2,  24'h000000, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 6'd1,  24'h0000FF, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 6'd0,  24'h000000, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 6'd1,  24'h00FFFF, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 6'd0,  24'h000000, 1'b0},
        '{8'hFF, 1'b0, 1'b0, 6'd0,  24'h000000, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 6'd1,  24'hFFFFFF, 1'b0},
        '{8'h00, 1'b0, 1'b0, 6'd0,  24'h000000, 1'b0},
        '{8'h00, 1'b0, 1'b1, 6'd1,  24'h000000, 1'b0},
        '{8'h80, 1'b0, 1'b1, 6'd24, 24'h000080, 1'b0},
        // restart mid-record: all-ones header, leading zeros cut at the limit
        '{8'hFF, 1'b1, 1'b1, 6'd0,  24'h000000, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 6'd0,  24'h000000, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 6'd0,  24'h000000, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 6'd30, 24'h000000, 1'b1},
        // header asking for too many entries and too many bytes
        '{8'h00, 1'b1, 1'b1, 6'd0,  24'h000000, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 6'd0,  24'h000000, 1'b0},
        '{8'hF0, 1'b0, 1'b1, 6'd0,  24'h000000, 1'b0},
        '{8'h0F, 1'b0, 1'b1, 6'd0,  24'h000000, 1'b0},
        '{8'h01, 1'b0, 1'b1, 6'd1,  24'h000001, 1'b1}
    };

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    packed_distribution_record_decoder_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Decoder model state.
    logic [5:0]  dec_pos;
    logic [3:0]  dec_run_cnt [NUM_RUNS];
    logic [2:0]  dec_run;
    logic [3:0]  dec_run_left;
    logic [15:0] dec_acc;
    logic [1:0]  dec_bytes_left;
    logic [4:0]  dec_emitted;
    logic        dec_waiting;
    logic [7:0]  dec_lead;
    logic        dec_rec_err;

    // Entries the decoder must still emit, oldest first.
    t_out_item pending_entries [$];

    int        error_count;
    int        cycle_count;
    int        taken_count;
    int        stall_left;
    bit        quiet;
    int        new_count;
    t_out_item first_new_entry;
    t_out_item got_entry;
    t_out_item exp_entry;

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    task automatic clear_record();
        dec_pos        = '0;
        for (int k = 0; k < NUM_RUNS; k++) dec_run_cnt[k] = '0;
        dec_run        = '0;
        dec_run_left   = '0;
        dec_acc        = '0;
        dec_bytes_left = '0;
        dec_emitted    = '0;
        dec_lead       = '0;
        dec_rec_err    = 1'b0;
    endtask

    task automatic push_entry(input logic [23:0] val);
        t_out_item e;
        e.entry_index      = dec_emitted;
        e.entry_millionths = val;
        e.last_entry       = (dec_emitted == 5'(MAX_ENTRIES_DEF - 1));
        e.format_error     = dec_rec_err;
        pending_entries.push_back(e);
        dec_emitted++;
    endtask

    task automatic pad_zeros();
        while (dec_emitted < MAX_ENTRIES_DEF) push_entry(24'd0);
        dec_run = RUNS_DONE;
    endtask

    // Move to the first non-empty run at or after 'from'; pad when none is left.
    task automatic find_run(input int from);
        int r;
        r = from;
        if (dec_emitted >= MAX_ENTRIES_DEF) begin
            dec_run = RUNS_DONE;
            return;
        end
        while (r < NUM_RUNS && dec_run_cnt[r] == 0) r++;
        if (r >= NUM_RUNS) begin
            pad_zeros();
        end else begin
            dec_run        = 3'(r);
            dec_run_left   = dec_run_cnt[r];
            dec_bytes_left = VAL_BYTES[r];
            dec_acc        = '0;
        end
    endtask

    task automatic decode_record_byte(input t_in_item it, output bit taken);
        logic [5:0] p;
        logic [7:0] b;
        int         total;
        int         nbytes;
        b     = it.record_byte;
        taken = 1'b1;
        if (it.start_of_record) begin
            clear_record();
            dec_waiting = 1'b0;
        end else if (dec_waiting) begin
            taken = 1'b0;
            return;
        end
        p = dec_pos;
        if (p == 6'd0) begin
            dec_lead = b;
        end else if (p == 6'd1) begin
            dec_run_cnt[0] = b[7:4];
            dec_run_cnt[1] = b[3:0];
        end else if (p == 6'd2) begin
            dec_run_cnt[2] = b[7:4];
            dec_run_cnt[3] = b[3:0];
        end else if (p == 6'd3) begin
            dec_run_cnt[4] = b[7:4];
            total  = dec_lead;
            nbytes = 0;
            for (int k = 0; k < NUM_RUNS; k++) begin
                total  += dec_run_cnt[k];
                nbytes += dec_run_cnt[k] * VAL_BYTES[k];
            end
            dec_rec_err = (total > MAX_ENTRIES_DEF) || (nbytes > VALUE_ROOM);
            for (int k = 0; k < dec_lead && dec_emitted < MAX_ENTRIES_DEF; k++)
                push_entry(24'd0);
            find_run(0);
        end else if (dec_run < RUNS_DONE) begin
            if (dec_bytes_left <= 2'd1) begin
                push_entry({dec_acc, b});
                dec_acc      = '0;
                dec_run_left = dec_run_left - 4'd1;
                if (dec_emitted >= MAX_ENTRIES_DEF)
                    dec_run = RUNS_DONE;
                else if (dec_run_left == 4'd0)
                    find_run(dec_run + 1);
                else
                    dec_bytes_left = VAL_BYTES[dec_run];
            end else begin
                dec_acc        = {dec_acc[7:0], b};
                dec_bytes_left = dec_bytes_left - 2'd1;
            end
        end
        // Last byte of the record: zero-fill whatever is still pending.
        if (p >= 6'(RECORD_BYTES_DEF - 1)) begin
            if (dec_run < RUNS_DONE) pad_zeros();
            dec_waiting = 1'b1;
        end
        dec_pos = p + 6'd1;
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset and cycle limit
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: ready dropped at random, in bursts of stall cycles
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each accepted entry against the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_entry = o_out_data;
            if (pending_entries.size() == 0) begin
                $error("unexpected entry: index %0d, value %0d",
                       got_entry.entry_index, got_entry.entry_millionths);
                error_count++;
            end else begin
                exp_entry = pending_entries.pop_front();
                if (got_entry.entry_index !== exp_entry.entry_index) begin
                    $error("entry_index: expected %0d, got %0d",
                           exp_entry.entry_index, got_entry.entry_index);
                    error_count++;
                end
                if (got_entry.entry_millionths !== exp_entry.entry_millionths) begin
                    $error("entry_millionths: expected %0d, got %0d",
                           exp_entry.entry_millionths, got_entry.entry_millionths);
                    error_count++;
                end
                if (got_entry.last_entry !== exp_entry.last_entry) begin
                    $error("last_entry: expected %0d, got %0d",
                           exp_entry.last_entry, got_entry.last_entry);
                    error_count++;
                end
                if (got_entry.format_error !== exp_entry.format_error) begin
                    $error("format_error: expected %0d, got %0d",
                           exp_entry.format_error, got_entry.format_error);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte side
    // ------------------------------------------------------------------------

    // Offer one item, hold it until accepted, then run the model on it.
    // Drop valid only for an idle burst, so valid never toggles within a step.
    task automatic send_byte(input logic [7:0] b, input logic sor);
        t_in_item it;
        bit       taken;
        int       first_new;
        it.record_byte     = b;
        it.start_of_record = sor;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        first_new = pending_entries.size();
        decode_record_byte(it, taken);
        new_count = pending_entries.size() - first_new;
        if (new_count > 0) first_new_entry = pending_entries[first_new];
        if (taken) taken_count++;
        quiet = (taken_count >= QUIET_ITEMS);
    endtask

    // Lower valid and hold off until every expected entry has come.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_entries.size() != 0);
    endtask

    // One random record: header, value bytes, and maybe stray bytes after it.
    task automatic send_record();
        logic [3:0] cnt [NUM_RUNS];
        logic [7:0] lead;
        int         mode;
        int         body;
        int         total;
        int         nbytes;
        int         r;
        mode = $urandom_range(0, 9);
        for (int k = 0; k < NUM_RUNS; k++) cnt[k] = 4'($urandom_range(0, 15));
        if (mode <= 5) begin
            // well-formed: trim runs until the header fits
            lead = 8'($urandom_range(0, 6));
            forever begin
                total  = lead;
                nbytes = 0;
                for (int k = 0; k < NUM_RUNS; k++) begin
                    total  += cnt[k];
                    nbytes += cnt[k] * VAL_BYTES[k];
                end
                if (total <= MAX_ENTRIES_DEF && nbytes <= VALUE_ROOM) break;
                r = $urandom_range(0, NUM_RUNS - 1);
                if (cnt[r] != 0) cnt[r] = cnt[r] - 4'd1;
            end
        end else if (mode <= 7) begin
            // raw header, usually over the limits
            lead = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, 40));
        end else if (mode == 8) begin
            // entry count fits but the values run past the record end
            lead   = 8'($urandom_range(0, 4));
            cnt[0] = '0;
            cnt[1] = 4'($urandom_range(8, 10));
            cnt[2] = 4'd15;
            cnt[3] = '0;
            cnt[4] = '0;
        end else begin
            // leading zeros and padding only
            lead = 8'($urandom_range(0, 34));
            for (int k = 0; k < NUM_RUNS; k++) cnt[k] = '0;
        end
        send_byte(lead, 1'b1);
        if ($urandom_range(0, 15) == 0) begin
            // restart inside the header
            send_byte(8'($urandom_range(0, 255)), 1'b0);
            return;
        end
        send_byte({cnt[0], cnt[1]}, 1'b0);
        send_byte({cnt[2], cnt[3]}, 1'b0);
        send_byte({cnt[4], 4'($urandom_range(0, 15))}, 1'b0);
        body = ($urandom_range(0, 7) == 0) ? $urandom_range(0, VALUE_ROOM - 1) : VALUE_ROOM;
        for (int k = 0; k < body; k++) send_byte(8'($urandom_range(0, 255)), 1'b0);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Main sequence: reset, directed table, pause, random records, drain.
    initial begin
        error_count = 0;
        cycle_count = 0;
        taken_count = 0;
        stall_left  = 0;
        quiet       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_ready = 1'b0;
        clear_record();
        dec_waiting = 1'b1;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table; cross-check the hand-typed rows.
        for (int row = 0; row < DIR_ROWS; row++) begin
            send_byte(DIR_TABLE[row].byte_val, DIR_TABLE[row].sor);
            if (DIR_TABLE[row].chk) begin
                if (new_count != DIR_TABLE[row].n_entries) begin
                    $error("row %0d entry count: expected %0d, got %0d",
                           row, DIR_TABLE[row].n_entries, new_count);
                    error_count++;
                end else if (new_count > 0) begin
                    if (first_new_entry.entry_millionths != DIR_TABLE[row].first_val) begin
                        $error("row %0d entry_millionths: expected %0d, got %0d", row,
                               DIR_TABLE[row].first_val, first_new_entry.entry_millionths);
                        error_count++;
                    end
                    if (first_new_entry.format_error != DIR_TABLE[row].err) begin
                        $error("row %0d format_error: expected %0d, got %0d", row,
                               DIR_TABLE[row].err, first_new_entry.format_error);
                        error_count++;
                    end
                end
            end
        end

        // Hold the sender until the decoder has caught up.
        drain();

        taken_count = 0;
        while (taken_count < RAND_ITEMS) send_record();

        // Let the last entries out, then watch for strays.
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
